>>> hdl/mm33_pkg.sv
// ----------------------------------------------------------------------------
// mm33_pkg: shared types and helpers for the 3x3 min/max morphology block
// Pixel and coordinate widths, register indexes, the job record passed
// from the front end through the job queue to the back end, and min/max.
// ----------------------------------------------------------------------------
package mm33_pkg;

    // Sizes
    localparam int PIX_BITS  = 16;
    localparam int MAX_COLS  = 1024;
    localparam int COL_BITS  = $clog2(MAX_COLS);
    localparam int ROW_BITS  = 12;
    localparam int WID_BITS  = 11;
    localparam int CFG_BITS  = 12;
    localparam int IDX_BITS  = 2;
    localparam int QDEPTH    = 4;
    localparam int QPTR_BITS = $clog2(QDEPTH);
    localparam int QCNT_BITS = $clog2(QDEPTH + 1);

    // Register indexes
    localparam logic [IDX_BITS-1:0] CFG_IDX_WIDTH  = 2'd0;
    localparam logic [IDX_BITS-1:0] CFG_IDX_HEIGHT = 2'd1;
    localparam logic [IDX_BITS-1:0] CFG_IDX_MODE   = 2'd2;

    // Register reset values
    localparam logic [WID_BITS-1:0] RST_WIDTH  = 11'd640;
    localparam logic [ROW_BITS-1:0] RST_HEIGHT = 12'd480;

    // Mode codes
    localparam logic MODE_ERODE  = 1'b0;
    localparam logic MODE_DILATE = 1'b1;

    // Result slots of a job, in release order
    localparam int EMIT_UL   = 0;  // (r-1, c-1)
    localparam int EMIT_UR   = 1;  // (r-1, c)   last column
    localparam int EMIT_LL   = 2;  // (r,   c-1) last row
    localparam int EMIT_LR   = 3;  // (r,   c)   last row and column
    localparam int EMIT_BITS = 4;

    typedef logic [PIX_BITS-1:0] t_pix;

    // One input pixel's work: column reductions plus which results it releases.
    // f* reduce rows r-2..r (top row masked above row 2), l* rows r-1..r.
    // Index 0 is column c-2, 1 is c-1, 2 is c.
    typedef struct packed {
        t_pix                 f0;
        t_pix                 f1;
        t_pix                 f2;
        t_pix                 l0;
        t_pix                 l1;
        t_pix                 l2;
        logic [ROW_BITS-1:0]  row;
        logic [COL_BITS-1:0]  col;
        logic [EMIT_BITS-1:0] emit;
    } t_job;

    // Neutral element of the reduction
    function automatic t_pix pix_ident(input logic mode);
        return (mode == MODE_DILATE) ? '0 : '1;
    endfunction

    // Min for erode, max for dilate
    function automatic t_pix pix_pick(input t_pix a, input t_pix b, input logic mode);
        if (mode == MODE_DILATE) begin
            return (a > b) ? a : b;
        end
        return (a < b) ? a : b;
    endfunction

endpackage

>>> hdl/mm33_front.sv
// ----------------------------------------------------------------------------
// mm33_front: pixel intake, line stores and window columns
// Tracks the raster position, decides which results each pixel releases,
// reads the two line stores, and reduces the three window columns into a job.
// ----------------------------------------------------------------------------
module mm33_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [mm33_pkg::PIX_BITS-1:0]  i_pixel_value,
    input  logic                           i_cfg_wr,
    input  logic [mm33_pkg::IDX_BITS-1:0]  i_cfg_index,
    input  logic [mm33_pkg::CFG_BITS-1:0]  i_cfg_data,
    input  logic                           i_release,
    output logic                           o_job_valid,
    output mm33_pkg::t_job                 o_job,
    output logic                           o_mode
);

    // Configuration registers
    logic [mm33_pkg::WID_BITS-1:0] r_cfg_width;
    logic [mm33_pkg::ROW_BITS-1:0] r_cfg_height;
    logic                          r_cfg_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= mm33_pkg::RST_WIDTH;
            r_cfg_height <= mm33_pkg::RST_HEIGHT;
            r_cfg_mode   <= mm33_pkg::MODE_ERODE;
        end else if (i_cfg_wr) begin
            unique case (i_cfg_index)
                mm33_pkg::CFG_IDX_WIDTH:  r_cfg_width  <= i_cfg_data[mm33_pkg::WID_BITS-1:0];
                mm33_pkg::CFG_IDX_HEIGHT: r_cfg_height <= i_cfg_data[mm33_pkg::ROW_BITS-1:0];
                mm33_pkg::CFG_IDX_MODE:   r_cfg_mode   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_mode = r_cfg_mode;

    // Credit count: items between intake and job release
    logic [mm33_pkg::QCNT_BITS-1:0] r_cnt, n_cnt;
    logic                           acc;

    assign full = (r_cnt == mm33_pkg::QCNT_BITS'(mm33_pkg::QDEPTH));
    assign acc  = push && !full;

    always_comb begin
        n_cnt = r_cnt;
        if (acc && !i_release) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!acc && i_release) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // Classification at intake
    logic [mm33_pkg::COL_BITS-1:0] r_col;
    logic [mm33_pkg::ROW_BITS-1:0] r_row;
    logic [mm33_pkg::WID_BITS-1:0] w_eff;
    logic [mm33_pkg::ROW_BITS-1:0] h_eff;
    logic                          last_col, last_row, row_ge1, col_ge1;
    logic [mm33_pkg::EMIT_BITS-1:0] emit;

    always_comb begin
        if (r_cfg_width < mm33_pkg::WID_BITS'(2)) begin
            w_eff = mm33_pkg::WID_BITS'(2);
        end else if (r_cfg_width > mm33_pkg::WID_BITS'(mm33_pkg::MAX_COLS)) begin
            w_eff = mm33_pkg::WID_BITS'(mm33_pkg::MAX_COLS);
        end else begin
            w_eff = r_cfg_width;
        end
        h_eff    = (r_cfg_height < mm33_pkg::ROW_BITS'(2)) ? mm33_pkg::ROW_BITS'(2)
                                                           : r_cfg_height;
        last_col = (mm33_pkg::WID_BITS'(r_col) >= (w_eff - 1'b1));
        last_row = (r_row >= (h_eff - 1'b1));
        row_ge1  = (r_row != '0);
        col_ge1  = (r_col != '0);
        emit     = '0;
        emit[mm33_pkg::EMIT_UL] = row_ge1 && col_ge1;
        emit[mm33_pkg::EMIT_UR] = row_ge1 && last_col;
        emit[mm33_pkg::EMIT_LL] = row_ge1 && last_row && col_ge1;
        emit[mm33_pkg::EMIT_LR] = row_ge1 && last_row && last_col;
    end

    // Raster position and credit count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (acc) begin
                if (last_col) begin
                    r_col <= '0;
                    r_row <= last_row ? '0 : (r_row + 1'b1);
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    // Stage 1: captured pixel and its classification
    logic                           r_s1_valid;
    mm33_pkg::t_pix                 r_s1_pix;
    logic [mm33_pkg::ROW_BITS-1:0]  r_s1_row;
    logic [mm33_pkg::COL_BITS-1:0]  r_s1_col;
    logic [mm33_pkg::EMIT_BITS-1:0] r_s1_emit;
    logic                           r_s1_top;
    logic                           r_s1_c2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s1_pix  <= i_pixel_value;
            r_s1_row  <= r_row;
            r_s1_col  <= r_col;
            r_s1_emit <= emit;
            r_s1_top  <= (r_row >= mm33_pkg::ROW_BITS'(2));
            r_s1_c2   <= (r_col >= mm33_pkg::COL_BITS'(2));
        end
    end

    // Line stores: read at intake, written back in the following cycle.
    // Consecutive pixels always sit in different columns.
    mm33_pkg::t_pix r_upper  [mm33_pkg::MAX_COLS];
    mm33_pkg::t_pix r_middle [mm33_pkg::MAX_COLS];
    mm33_pkg::t_pix r_rd_up, r_rd_mid;

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rd_up  <= r_upper[r_col];
            r_rd_mid <= r_middle[r_col];
        end
        if (r_s1_valid) begin
            r_upper[r_s1_col]  <= r_rd_mid;
            r_middle[r_s1_col] <= r_s1_pix;
        end
    end

    // Window columns: [0..2] column c-2, [3..5] column c-1, rows top to bottom
    mm33_pkg::t_pix r_wc [6];

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_wc[0] <= r_wc[3];
            r_wc[1] <= r_wc[4];
            r_wc[2] <= r_wc[5];
            r_wc[3] <= r_rd_up;
            r_wc[4] <= r_rd_mid;
            r_wc[5] <= r_s1_pix;
        end
    end

    // Stage 2: per-column reductions
    mm33_pkg::t_pix v    [3][3];
    mm33_pkg::t_pix cf   [3];
    mm33_pkg::t_pix cl   [3];
    mm33_pkg::t_pix m12;

    always_comb begin
        v[0][0] = r_wc[0];
        v[0][1] = r_wc[1];
        v[0][2] = r_wc[2];
        v[1][0] = r_wc[3];
        v[1][1] = r_wc[4];
        v[1][2] = r_wc[5];
        v[2][0] = r_rd_up;
        v[2][1] = r_rd_mid;
        v[2][2] = r_s1_pix;
        m12     = '0;
        for (int i = 0; i < 3; i++) begin
            m12   = mm33_pkg::pix_pick(v[i][1], v[i][2], r_cfg_mode);
            cl[i] = m12;
            cf[i] = r_s1_top ? mm33_pkg::pix_pick(v[i][0], m12, r_cfg_mode) : m12;
        end
        // column c-2 lies left of the frame for the first two columns
        if (!r_s1_c2) begin
            cf[0] = mm33_pkg::pix_ident(r_cfg_mode);
            cl[0] = mm33_pkg::pix_ident(r_cfg_mode);
        end
    end

    assign o_job_valid = r_s1_valid;
    assign o_job.f0    = cf[0];
    assign o_job.f1    = cf[1];
    assign o_job.f2    = cf[2];
    assign o_job.l0    = cl[0];
    assign o_job.l1    = cl[1];
    assign o_job.l2    = cl[2];
    assign o_job.row   = r_s1_row;
    assign o_job.col   = r_s1_col;
    assign o_job.emit  = r_s1_emit;

    // Checks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= mm33_pkg::QCNT_BITS'(mm33_pkg::QDEPTH))
        else $error("credit count above queue depth");

    a_no_col_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && acc) |-> (r_col != r_s1_col))
        else $error("line store read and write hit the same column");

    a_row0_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && (r_s1_row == '0)) |-> (r_s1_emit == '0))
        else $error("first row released a result");

endmodule

>>> hdl/mm33_queue.sv
// ----------------------------------------------------------------------------
// mm33_queue: short job queue between front end and back end
// Register-based FIFO of job records; the front end holds credits so
// that a push never meets a full queue.
// ----------------------------------------------------------------------------
module mm33_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mm33_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_valid,
    output mm33_pkg::t_job o_job
);

    mm33_pkg::t_job                 r_mem [mm33_pkg::QDEPTH];
    logic [mm33_pkg::QPTR_BITS-1:0] r_wp, r_rp;
    logic [mm33_pkg::QCNT_BITS-1:0] r_cnt;
    logic                           pop_ok;

    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign pop_ok  = i_pop && o_valid;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == mm33_pkg::QPTR_BITS'(mm33_pkg::QDEPTH - 1)) ? '0
                                                                             : r_wp + 1'b1;
            end
            if (pop_ok) begin
                r_rp <= (r_rp == mm33_pkg::QPTR_BITS'(mm33_pkg::QDEPTH - 1)) ? '0
                                                                             : r_rp + 1'b1;
            end
            if (i_push && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && pop_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // Checks
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt != mm33_pkg::QCNT_BITS'(mm33_pkg::QDEPTH)))
        else $error("job pushed into a full queue");

endmodule

>>> hdl/mm33_back.sv
// ----------------------------------------------------------------------------
// mm33_back: result sequencer and output register
// Walks the results released by the head job in order, finishes each
// window reduction, and presents one result at a time on the output.
// ----------------------------------------------------------------------------
module mm33_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_job_valid,
    input  mm33_pkg::t_job                 i_job,
    input  logic                           i_mode,
    output logic                           o_release,
    output logic                           empty,
    input  logic                           pop,
    output logic [mm33_pkg::PIX_BITS-1:0]  o_out_value,
    output logic [mm33_pkg::ROW_BITS-1:0]  o_out_row,
    output logic [mm33_pkg::COL_BITS-1:0]  o_out_col,
    output logic                           o_run_last,
    output logic                           o_frame_done
);

    logic [mm33_pkg::EMIT_BITS-1:0] r_sent;
    logic [mm33_pkg::EMIT_BITS-1:0] pending, sel, rest;
    logic                           r_ovalid;
    logic                           slot_free, load, upper, use0;
    mm33_pkg::t_pix                 x0, x1, x2, val;
    logic [mm33_pkg::ROW_BITS-1:0]  row;
    logic [mm33_pkg::COL_BITS-1:0]  col;

    assign empty     = !r_ovalid;
    assign slot_free = !r_ovalid || pop;

    // Pick the next result of the head job
    always_comb begin
        pending = i_job.emit & ~r_sent;
        sel     = pending & (~pending + 1'b1);
        rest    = pending & ~sel;
        load    = i_job_valid && (pending != '0) && slot_free;
        // release when the job is exhausted, or empty from the start
        o_release = i_job_valid && ((pending == '0) || (load && (rest == '0)));

        upper = sel[mm33_pkg::EMIT_UL] || sel[mm33_pkg::EMIT_UR];
        use0  = sel[mm33_pkg::EMIT_UL] || sel[mm33_pkg::EMIT_LL];
        x1    = upper ? i_job.f1 : i_job.l1;
        x2    = upper ? i_job.f2 : i_job.l2;
        x0    = use0 ? (upper ? i_job.f0 : i_job.l0) : mm33_pkg::pix_ident(i_mode);
        val   = mm33_pkg::pix_pick(x0, mm33_pkg::pix_pick(x1, x2, i_mode), i_mode);
        row   = upper ? (i_job.row - 1'b1) : i_job.row;
        col   = use0 ? (i_job.col - 1'b1) : i_job.col;
    end

    // Sequencer state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sent   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_release) begin
                r_sent <= '0;
            end else if (load) begin
                r_sent <= r_sent | sel;
            end
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (pop) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            o_out_value  <= val;
            o_out_row    <= row;
            o_out_col    <= col;
            o_run_last   <= (rest == '0);
            o_frame_done <= sel[mm33_pkg::EMIT_LR];
        end
    end

    // Checks
    a_sent_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job_valid |-> ((r_sent & ~i_job.emit) == '0))
        else $error("sent mask outside head job");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && o_frame_done) |-> o_run_last)
        else $error("frame end result not last of its pixel");

endmodule

>>> hdl/morphology_3x3_min_max.sv
// ----------------------------------------------------------------------------
// morphology_3x3_min_max: streaming 3x3 grayscale erosion / dilation
// Throughput: 1 pixel and 1 result per cycle unless full or an idle pop stalls the flow;
//   last-row pixels past column 0 release 2 results (4 at last column), so the
//   4-entry job queue fills and full stalls intake.
// Reset: synchronous; clears position, pipeline and queue, sets 640x480 erode.
//   Line stores are not cleared; no clearing pass, pixels are accepted at once.
// ----------------------------------------------------------------------------
module morphology_3x3_min_max (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  logic [mm33_pkg::PIX_BITS-1:0]  i_pixel_value,
    output logic                           empty,
    input  logic                           pop,
    output logic [mm33_pkg::PIX_BITS-1:0]  o_out_value,
    output logic [mm33_pkg::ROW_BITS-1:0]  o_out_row,
    output logic [mm33_pkg::COL_BITS-1:0]  o_out_col,
    output logic                           o_run_last,
    output logic                           o_frame_done,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mm33_pkg::IDX_BITS-1:0]  i_cfg_index,
    input  logic [mm33_pkg::CFG_BITS-1:0]  i_cfg_data
);

    logic           push_job, job_valid, release_job, mode;
    mm33_pkg::t_job front_job, head_job;

    // Register writes are always taken
    assign o_cfg_ready = 1'b1;

    mm33_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_pixel_value (i_pixel_value),
        .i_cfg_wr      (i_cfg_valid && o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_release     (release_job),
        .o_job_valid   (push_job),
        .o_job         (front_job),
        .o_mode        (mode)
    );

    mm33_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_job),
        .i_job   (front_job),
        .i_pop   (release_job),
        .o_valid (job_valid),
        .o_job   (head_job)
    );

    mm33_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (job_valid),
        .i_job        (head_job),
        .i_mode       (mode),
        .o_release    (release_job),
        .empty        (empty),
        .pop          (pop),
        .o_out_value  (o_out_value),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_run_last   (o_run_last),
        .o_frame_done (o_frame_done)
    );

endmodule
